// ===== design/aabb_sweep_offset_clipper_unit_macros.svh =====
// -----------------------------------------------------------------------------
// aabb_sweep_offset_clipper_unit_macros.svh
// Assertion macros shared by the clipper RTL.
// -----------------------------------------------------------------------------
`ifndef AABB_SWEEP_OFFSET_CLIPPER_UNIT_MACROS_SVH
`define AABB_SWEEP_OFFSET_CLIPPER_UNIT_MACROS_SVH

// same-cycle implication
`define ASOC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/asoc_pkg.sv =====
// -----------------------------------------------------------------------------
// asoc_pkg
// Types, axis indexes and helpers for the AABB sweep clipper.
// -----------------------------------------------------------------------------
package asoc_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned NUM_AXES = 3;

	typedef logic signed [COORD_W-1:0] q16_t;
	typedef logic [1:0] axis_idx_t;

	localparam axis_idx_t AX_X = 2'd0;
	localparam axis_idx_t AX_Y = 2'd1;
	localparam axis_idx_t AX_Z = 2'd2;

	typedef enum logic {
		REQ_START    = 1'b0,
		REQ_OBSTACLE = 1'b1
	} req_type_t;

	// strict overlap on one axis; touching faces do not overlap
	function automatic logic overlaps(input q16_t mov_lo, input q16_t mov_hi,
		input q16_t obs_lo, input q16_t obs_hi);
		return !((mov_hi <= obs_lo) || (mov_lo >= obs_hi));
	endfunction

endpackage

// ===== design/asoc_if.sv =====
// -----------------------------------------------------------------------------
// asoc_if
// Valid/ready channels for request beats and result beats.
// -----------------------------------------------------------------------------
interface asoc_req_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic signed [31:0]         box_lo_x;
	logic signed [31:0]         box_lo_y;
	logic signed [31:0]         box_lo_z;
	logic signed [31:0]         box_hi_x;
	logic signed [31:0]         box_hi_y;
	logic signed [31:0]         box_hi_z;
	logic signed [31:0]         move_x;
	logic signed [31:0]         move_y;
	logic signed [31:0]         move_z;

	modport source (
		output valid, req_type, box_lo_x, box_lo_y, box_lo_z,
		box_hi_x, box_hi_y, box_hi_z, move_x, move_y, move_z,
		input ready
	);
	modport sink (
		input valid, req_type, box_lo_x, box_lo_y, box_lo_z,
		box_hi_x, box_hi_y, box_hi_z, move_x, move_y, move_z,
		output ready
	);
endinterface

interface asoc_res_if;
	logic                       valid;
	logic                       ready;
	logic signed [31:0]         clip_x;
	logic signed [31:0]         clip_y;
	logic signed [31:0]         clip_z;
	logic                       halt_x;
	logic                       halt_y;
	logic                       halt_z;

	modport source (
		output valid, clip_x, clip_y, clip_z, halt_x, halt_y, halt_z,
		input ready
	);
	modport sink (
		input valid, clip_x, clip_y, clip_z, halt_x, halt_y, halt_z,
		output ready
	);
endinterface

// ===== design/asoc_axis_clip.sv =====
// -----------------------------------------------------------------------------
// asoc_axis_clip
// Clips one axis move against one obstacle's faces on that axis; 33-bit gaps, no wrap.
// -----------------------------------------------------------------------------
module asoc_axis_clip (
	input  asoc_pkg::q16_t move,
	input  asoc_pkg::q16_t mov_lo,
	input  asoc_pkg::q16_t mov_hi,
	input  asoc_pkg::q16_t obs_lo,
	input  asoc_pkg::q16_t obs_hi,
	input  logic           side_ovl,
	output asoc_pkg::q16_t clip,
	output logic           hit
);
	import asoc_pkg::*;

	logic signed [COORD_W:0] gap_pos;
	logic signed [COORD_W:0] gap_neg;
	logic signed [COORD_W:0] gap_neg_inc;
	logic signed [COORD_W:0] move_ext;
	logic                    pos_hit;
	logic                    neg_hit;

	assign move_ext    = {move[COORD_W-1], move};
	assign gap_pos     = {obs_lo[COORD_W-1], obs_lo} - {mov_hi[COORD_W-1], mov_hi};
	assign gap_neg     = {obs_hi[COORD_W-1], obs_hi} - {mov_lo[COORD_W-1], mov_lo};
	// epsilon step when moving negative: one LSB
	assign gap_neg_inc = gap_neg + (COORD_W+1)'(1);

	assign pos_hit = side_ovl && (move > 0) && !gap_pos[COORD_W] && (gap_pos < move_ext);
	assign neg_hit = side_ovl && (move < 0) && (gap_neg <= 0) && (gap_neg > move_ext);

	always_comb begin
		priority if (pos_hit) begin
			clip = gap_pos[COORD_W-1:0];
		end else if (neg_hit) begin
			clip = gap_neg_inc[COORD_W-1:0];
		end else begin
			clip = move;
		end
	end

	assign hit = pos_hit || neg_hit;

endmodule

// ===== design/aabb_sweep_offset_clipper_unit.sv =====
// -----------------------------------------------------------------------------
// aabb_sweep_offset_clipper_unit
// Axis-separated clipping of a planned move against a stream of obstacle boxes.
// -----------------------------------------------------------------------------
// Usage:
//   req carries one beat per item. A start beat (req_type 0) loads the mover
//   box and the planned move and clears the halt flags; an obstacle beat
//   (req_type 1) clips each axis move against that box. Move fields are
//   ignored on obstacle beats.
//   res returns one beat per request beat: the current clipped moves and
//   halt flags after that item.
//   Path: an accepted request beat passes the input register, then the
//   state/result register, which drives res.
//   Throughput: one beat per cycle while res is not held off; the state
//   update is built from combinational 33-bit subtracts and compares per axis.
//   Reset: mover box, moves and halt flags read zero; no beats in flight.
//   Stall: while res is held off, the result and state hold, the input
//   register fills and req.ready drops until res drains.
// -----------------------------------------------------------------------------
module aabb_sweep_offset_clipper_unit (
	input logic  clk,
	input logic  arst_n,
	asoc_req_if.sink   req,
	asoc_res_if.source res
);
	import asoc_pkg::*;

	logic       valid_s1;
	req_type_t  type_s1;
	q16_t       lo_s1 [NUM_AXES];
	q16_t       hi_s1 [NUM_AXES];
	q16_t       move_s1 [NUM_AXES];

	q16_t       mov_lo_q [NUM_AXES];
	q16_t       mov_hi_q [NUM_AXES];
	q16_t       move_q [NUM_AXES];
	logic [NUM_AXES-1:0] halt_q;
	logic       res_valid_q;

	logic       adv;
	logic [NUM_AXES-1:0] ovl;
	logic [NUM_AXES-1:0] hit;
	q16_t       clip [NUM_AXES];

	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			type_s1        <= req_type_t'(req.req_type);
			lo_s1[AX_X]    <= req.box_lo_x;
			lo_s1[AX_Y]    <= req.box_lo_y;
			lo_s1[AX_Z]    <= req.box_lo_z;
			hi_s1[AX_X]    <= req.box_hi_x;
			hi_s1[AX_Y]    <= req.box_hi_y;
			hi_s1[AX_Z]    <= req.box_hi_z;
			move_s1[AX_X]  <= req.move_x;
			move_s1[AX_Y]  <= req.move_y;
			move_s1[AX_Z]  <= req.move_z;
		end
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_ovl
		assign ovl[a] = overlaps(mov_lo_q[a], mov_hi_q[a], lo_s1[a], hi_s1[a]);
	end

	asoc_axis_clip u_clip_x (
		.move     (move_q[AX_X]),
		.mov_lo   (mov_lo_q[AX_X]),
		.mov_hi   (mov_hi_q[AX_X]),
		.obs_lo   (lo_s1[AX_X]),
		.obs_hi   (hi_s1[AX_X]),
		.side_ovl (ovl[AX_Y] && ovl[AX_Z]),
		.clip     (clip[AX_X]),
		.hit      (hit[AX_X])
	);

	asoc_axis_clip u_clip_y (
		.move     (move_q[AX_Y]),
		.mov_lo   (mov_lo_q[AX_Y]),
		.mov_hi   (mov_hi_q[AX_Y]),
		.obs_lo   (lo_s1[AX_Y]),
		.obs_hi   (hi_s1[AX_Y]),
		.side_ovl (ovl[AX_X] && ovl[AX_Z]),
		.clip     (clip[AX_Y]),
		.hit      (hit[AX_Y])
	);

	asoc_axis_clip u_clip_z (
		.move     (move_q[AX_Z]),
		.mov_lo   (mov_lo_q[AX_Z]),
		.mov_hi   (mov_hi_q[AX_Z]),
		.obs_lo   (lo_s1[AX_Z]),
		.obs_hi   (hi_s1[AX_Z]),
		.side_ovl (ovl[AX_X] && ovl[AX_Y]),
		.clip     (clip[AX_Z]),
		.hit      (hit[AX_Z])
	);

	// state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				mov_lo_q[i] <= '0;
				mov_hi_q[i] <= '0;
				move_q[i]   <= '0;
			end
			halt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				res_valid_q <= 1'b1;
				unique case (type_s1)
					REQ_START: begin
						mov_lo_q <= lo_s1;
						mov_hi_q <= hi_s1;
						move_q   <= move_s1;
						halt_q   <= '0;
					end
					REQ_OBSTACLE: begin
						move_q <= clip;
						halt_q <= halt_q | hit;
					end
					default: begin
						res_valid_q <= 1'b1;
					end
				endcase
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid  = res_valid_q;
	assign res.clip_x = move_q[AX_X];
	assign res.clip_y = move_q[AX_Y];
	assign res.clip_z = move_q[AX_Z];
	assign res.halt_x = halt_q[AX_X];
	assign res.halt_y = halt_q[AX_Y];
	assign res.halt_z = halt_q[AX_Z];

`include "aabb_sweep_offset_clipper_unit_macros.svh"

	`ASOC_ASSERT_NEXT(a_start_clears_halt, clk, arst_n, adv && (type_s1 == REQ_START), halt_q == '0, "start beat left a halt flag set")
	`ASOC_ASSERT_NEXT(a_halt_sticky, clk, arst_n, adv && (type_s1 == REQ_OBSTACLE), (halt_q & $past(halt_q)) == $past(halt_q), "halt flag cleared by obstacle beat")
	`ASOC_ASSERT_NEXT(a_adv_gives_result, clk, arst_n, adv, res_valid_q, "advanced beat produced no result")
	`ASOC_ASSERT_NOW(a_block_only_when_full, clk, arst_n, !req.ready, valid_s1 && res_valid_q && !res.ready, "input blocked without a stall")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AABB sweep clipper: a directed table of corner
// beats, then random start/obstacle sequences. Each accepted request beat is
// run through a local model of the clipper, and every result beat is compared
// in order. Both channels idle at random in bursts.
// -----------------------------------------------------------------------------
module tb_top;
	import asoc_pkg::*;

	localparam q16_t Q1    = 32'sh0001_0000;
	localparam q16_t Q_MIN = 32'sh8000_0000;
	localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
	localparam int   N_RANDOM   = 1030;
	localparam int   CALM_TAIL  = 150;
	localparam int   STALL_LIMIT = 1000;

	typedef struct {
		req_type_t kind;
		q16_t      lo[3];
		q16_t      hi[3];
		q16_t      mv[3];
	} clip_req_t;

	// halt bits indexed by axis
	typedef struct {
		q16_t       clip[3];
		logic [2:0] halt;
	} clip_res_t;

	typedef struct {
		clip_req_t rq;
		bit        lit;
		clip_res_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	asoc_req_if req ();
	asoc_res_if res ();

	aabb_sweep_offset_clipper_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res)
	);

	always #4 clk = ~clk;

	// local copy of the mover and its remaining travel
	q16_t       body_lo[3];
	q16_t       body_hi[3];
	q16_t       travel[3];
	logic [2:0] blocked;

	clip_res_t  clip_due[$];
	dir_row_t   plan[$];
	int         errs = 0;
	bit         idle_on = 1'b1;
	int         quiet_cycles = 0;
	clip_res_t  head;

	function automatic clip_req_t mk(req_type_t k, q16_t lx, q16_t ly, q16_t lz,
		q16_t hx, q16_t hy, q16_t hz, q16_t mx, q16_t my, q16_t mz);
		clip_req_t r;
		r.kind = k;
		r.lo[AX_X] = lx; r.lo[AX_Y] = ly; r.lo[AX_Z] = lz;
		r.hi[AX_X] = hx; r.hi[AX_Y] = hy; r.hi[AX_Z] = hz;
		r.mv[AX_X] = mx; r.mv[AX_Y] = my; r.mv[AX_Z] = mz;
		return r;
	endfunction

	function automatic void row(clip_req_t rq);
		dir_row_t d;
		d.rq = rq;
		d.lit = 1'b0;
		plan.push_back(d);
	endfunction

	function automatic void row_lit(clip_req_t rq, q16_t cx, q16_t cy, q16_t cz,
		logic [2:0] h);
		dir_row_t d;
		d.rq = rq;
		d.lit = 1'b1;
		d.want.clip[AX_X] = cx;
		d.want.clip[AX_Y] = cy;
		d.want.clip[AX_Z] = cz;
		d.want.halt = h;
		plan.push_back(d);
	endfunction

	function automatic void clip_travel(input clip_req_t r, output clip_res_t o);
		logic signed [32:0] gap;
		q16_t d;
		int b;
		int c;
		bit ok;
		if (r.kind == REQ_START) begin
			for (int i = 0; i < 3; i++) begin
				body_lo[i] = r.lo[i];
				body_hi[i] = r.hi[i];
				travel[i] = r.mv[i];
			end
			blocked = 3'b000;
		end else begin
			for (int a = 0; a < 3; a++) begin
				b = (a == 0) ? 1 : 0;
				c = (a == 2) ? 1 : 2;
				ok = !(body_hi[b] <= r.lo[b] || body_lo[b] >= r.hi[b]) &&
					!(body_hi[c] <= r.lo[c] || body_lo[c] >= r.hi[c]);
				if (!ok)
					continue;
				d = travel[a];
				if (d > 0 && body_hi[a] <= r.lo[a]) begin
					gap = {r.lo[a][31], r.lo[a]} - {body_hi[a][31], body_hi[a]};
					if (gap < d) begin
						blocked[a] = 1'b1;
						d = gap[31:0];
					end
				end
				if (d < 0 && body_lo[a] >= r.hi[a]) begin
					gap = {r.hi[a][31], r.hi[a]} - {body_lo[a][31], body_lo[a]};
					if (gap > d) begin
						blocked[a] = 1'b1;
						d = gap[31:0] + 32'sd1;
					end
				end
				travel[a] = d;
			end
		end
		for (int i = 0; i < 3; i++)
			o.clip[i] = travel[i];
		o.halt = blocked;
	endfunction

	function automatic q16_t rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return Q_MIN;
					1: return Q_MAX;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return int'($urandom_range(0, 32'd33554432)) - 16777216;
		endcase
	endfunction

	function automatic clip_req_t gen_start();
		clip_req_t r;
		q16_t t;
		r.kind = REQ_START;
		for (int i = 0; i < 3; i++) begin
			r.lo[i] = rand_coord();
			r.hi[i] = r.lo[i] + q16_t'($urandom_range(1, 8 * 65536));
			case ($urandom_range(0, 19))
				0: begin
					t = r.lo[i];
					r.lo[i] = r.hi[i];
					r.hi[i] = t;
				end
				1: r.hi[i] = r.lo[i];
				2: r.hi[i] = $urandom;
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0: r.mv[i] = 0;
				1: r.mv[i] = $urandom;
				default: r.mv[i] = int'($urandom_range(0, 32 * 65536)) - 16 * 65536;
			endcase
		end
		return r;
	endfunction

	// mostly boxes that overlap two axes and sit ahead on the third
	function automatic clip_req_t gen_obstacle();
		clip_req_t r;
		int ahead;
		q16_t gap;
		q16_t size;
		bit fwd;
		r.kind = REQ_OBSTACLE;
		ahead = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) begin
			r.mv[i] = $urandom;
			size = $urandom_range(0, 4 * 65536);
			if (i == ahead) begin
				gap = ($urandom_range(0, 4) == 0) ? 0 : q16_t'($urandom_range(0, 20 * 65536));
				fwd = (travel[i] >= 0);
				if ($urandom_range(0, 5) == 0)
					fwd = !fwd;
				if (fwd) begin
					r.lo[i] = body_hi[i] + gap;
					r.hi[i] = r.lo[i] + size;
				end else begin
					r.hi[i] = body_lo[i] - gap;
					r.lo[i] = r.hi[i] - size;
				end
			end else begin
				case ($urandom_range(0, 7))
					0: begin
						r.lo[i] = body_hi[i];
						r.hi[i] = r.lo[i] + size;
					end
					1: begin
						r.hi[i] = body_lo[i];
						r.lo[i] = r.hi[i] - size;
					end
					2: begin
						r.lo[i] = rand_coord();
						r.hi[i] = rand_coord();
					end
					default: begin
						r.lo[i] = body_lo[i] - q16_t'($urandom_range(0, 2 * 65536));
						r.hi[i] = body_hi[i] + q16_t'($urandom_range(0, 2 * 65536));
					end
				endcase
			end
		end
		return r;
	endfunction

	function automatic clip_req_t gen_noise();
		clip_req_t r;
		r.kind = req_type_t'($urandom_range(0, 1));
		for (int i = 0; i < 3; i++) begin
			r.lo[i] = $urandom;
			r.hi[i] = $urandom;
			r.mv[i] = $urandom;
		end
		return r;
	endfunction

	task automatic send_beat(input clip_req_t r, input bit use_lit, input clip_res_t lit_res);
		int gap;
		clip_res_t p;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.req_type <= r.kind;
		req.box_lo_x <= r.lo[AX_X];
		req.box_lo_y <= r.lo[AX_Y];
		req.box_lo_z <= r.lo[AX_Z];
		req.box_hi_x <= r.hi[AX_X];
		req.box_hi_y <= r.hi[AX_Y];
		req.box_hi_z <= r.hi[AX_Z];
		req.move_x   <= r.mv[AX_X];
		req.move_y   <= r.mv[AX_Y];
		req.move_z   <= r.mv[AX_Z];
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		clip_travel(r, p);
		clip_due.push_back(use_lit ? lit_res : p);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (clip_due.size() == 0) begin
				$error("result beat with nothing expected");
				errs++;
			end else begin
				head = clip_due.pop_front();
				check_field("clip_x", head.clip[AX_X], res.clip_x);
				check_field("clip_y", head.clip[AX_Y], res.clip_y);
				check_field("clip_z", head.clip[AX_Z], res.clip_z);
				check_field("halt_x", 32'(head.halt[AX_X]), 32'(res.halt_x));
				check_field("halt_y", 32'(head.halt[AX_Y]), 32'(res.halt_y));
				check_field("halt_z", 32'(head.halt[AX_Z]), 32'(res.halt_z));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (res.valid && res.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			res.ready <= 1'b1;
		end
	end

	initial begin
		clip_req_t r;
		clip_res_t none;
		int sent;
		int burst;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = REQ_START;
		req.box_lo_x = '0; req.box_lo_y = '0; req.box_lo_z = '0;
		req.box_hi_x = '0; req.box_hi_y = '0; req.box_hi_z = '0;
		req.move_x = '0; req.move_y = '0; req.move_z = '0;
		for (int i = 0; i < 3; i++) begin
			body_lo[i] = 0;
			body_hi[i] = 0;
			travel[i] = 0;
		end
		blocked = 3'b000;

		// obstacle before any start sees the zero mover
		row_lit(mk(REQ_OBSTACLE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 3'b000);
		row_lit(mk(REQ_START, 0, 0, 0, Q1, Q1, Q1, 5 * Q1, -5 * Q1, 0),
			5 * Q1, -5 * Q1, 0, 3'b000);
		row_lit(mk(REQ_OBSTACLE, 2 * Q1, 0, 0, 3 * Q1, Q1, Q1, 0, 0, 0),
			Q1, -5 * Q1, 0, 3'b001);
		row(mk(REQ_OBSTACLE, 0, -3 * Q1, 0, Q1, -2 * Q1, Q1, 0, 0, 0));
		// zero gap moving negative
		row(mk(REQ_OBSTACLE, 0, -Q1, 0, Q1, 0, Q1, 0, 0, 0));
		// touching faces
		row(mk(REQ_OBSTACLE, Q1, Q1, 0, 2 * Q1, 2 * Q1, Q1, 0, 0, 0));
		// move fields on an obstacle are don't-care
		row(mk(REQ_OBSTACLE, Q1, 0, 0, 2 * Q1, Q1, Q1, 32'shDEAD_BEEF, 32'sh1234_5678, Q_MIN));
		row_lit(mk(REQ_START, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX),
			Q_MAX, Q_MIN, Q_MAX, 3'b000);
		row_lit(mk(REQ_OBSTACLE, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0),
			0, Q_MIN, Q_MAX, 3'b001);
		row_lit(mk(REQ_OBSTACLE, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0),
			0, 1, Q_MAX, 3'b011);
		row_lit(mk(REQ_OBSTACLE, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0),
			0, 1, 0, 3'b111);
		// gaps wider than 32 bits
		row_lit(mk(REQ_START, Q_MIN, 0, 0, Q_MIN, Q1, Q1, Q_MAX, 0, 0), Q_MAX, 0, 0, 3'b000);
		row_lit(mk(REQ_OBSTACLE, Q_MAX, 0, 0, Q_MAX, Q1, Q1, 0, 0, 0), Q_MAX, 0, 0, 3'b000);
		row_lit(mk(REQ_START, Q_MAX, 0, 0, Q_MAX, Q1, Q1, Q_MIN, 0, 0), Q_MIN, 0, 0, 3'b000);
		row_lit(mk(REQ_OBSTACLE, Q_MIN, 0, 0, Q_MIN, Q1, Q1, 0, 0, 0), Q_MIN, 0, 0, 3'b000);
		// inverted boxes
		row(mk(REQ_START, 2 * Q1, 2 * Q1, 2 * Q1, 0, 0, 0, 3 * Q1, -3 * Q1, 3 * Q1));
		row(mk(REQ_OBSTACLE, 4 * Q1, Q1, Q1, 5 * Q1, -Q1, -Q1, 0, 0, 0));
		row(mk(REQ_START, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		row(mk(REQ_OBSTACLE, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		row(mk(REQ_START, 0, 0, 0, Q1, Q1, Q1, Q1 / 2, -Q1 / 2, -7 * Q1));
		row(mk(REQ_OBSTACLE, 0, 0, -3 * Q1, Q1, Q1, -Q1, 0, 0, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			send_beat(plan[i].rq, plan[i].lit, plan[i].want);

		sent = 0;
		while (sent < N_RANDOM) begin
			idle_on = (sent < N_RANDOM - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0) begin
				send_beat(gen_noise(), 1'b0, none);
				sent++;
			end else begin
				send_beat(gen_start(), 1'b0, none);
				sent++;
				burst = $urandom_range(2, 10);
				for (int k = 0; k < burst; k++) begin
					r = ($urandom_range(0, 9) == 0) ? gen_noise() : gen_obstacle();
					if (r.kind == REQ_START)
						r.kind = REQ_OBSTACLE;
					send_beat(r, 1'b0, none);
					sent++;
				end
			end
		end
		req.valid <= 1'b0;
		idle_on = 1'b0;

		while (clip_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errs == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
